>>> hw/rtl/npc_pkg.sv
// Shared types and constants for the nearest palette color core.
package npc_pkg;

  // Fixed widths of the command and result word fields, the size register and the distance
  localparam int unsigned IdxPortW = 6;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned DistW    = 18;

  // Operation codes carried on func_i
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_CONVERT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  // One classified command word as it sits in the queue
  typedef struct packed {
    op_e                 op;
    logic [IdxPortW-1:0] idx;
    logic                idx_ok;
    logic [ChanW-1:0]    red;
    logic [ChanW-1:0]    green;
    logic [ChanW-1:0]    blue;
    logic                sel;
  } cmd_t;

  // Status from the execution side back to the front end
  typedef struct packed {
    logic pop;
    logic init;
  } back_stat_t;

endpackage

>>> hw/rtl/npc_front.sv
// Front end: accepts command words, classifies them and queues them.
module npc_front #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func_i,
  input  logic [npc_pkg::IdxPortW-1:0]    entry_index_i,
  input  logic [npc_pkg::ChanW-1:0]       color_red_i,
  input  logic [npc_pkg::ChanW-1:0]       color_green_i,
  input  logic [npc_pkg::ChanW-1:0]       color_blue_i,
  input  logic                            select_flag_i,
  input  npc_pkg::back_stat_t             stat_i,
  output npc_pkg::cmd_t                   head_o,
  output logic                            head_valid_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  npc_pkg::cmd_t q_mem [QDepth];
  npc_pkg::cmd_t cmd_in;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            full;

  // Classify the incoming word
  always_comb begin
    cmd_in.op     = npc_pkg::op_e'(func_i);
    cmd_in.idx    = entry_index_i;
    cmd_in.idx_ok = (32'(entry_index_i) < PALETTE_DEPTH);
    cmd_in.red    = color_red_i;
    cmd_in.green  = color_green_i;
    cmd_in.blue   = color_blue_i;
    cmd_in.sel    = select_flag_i;
  end

  // Hold off new words while the queue is full or the reset table sweep runs
  assign full         = (cnt_q == CntW'(QDepth));
  assign busy         = full || stat_i.init;
  assign push         = start && !busy;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (stat_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, stat_i.pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued word
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  a_ptr_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("queue empty but pointers differ");

endmodule

>>> hw/rtl/npc_back.sv
// Execution side: palette tables, nearest-color scan and hit counters.
module npc_back #(
  parameter int unsigned PALETTE_DEPTH = 64,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [npc_pkg::SizeW-1:0]       cfg_wdata_i,
  input  npc_pkg::cmd_t                   head_i,
  input  logic                            head_valid_i,
  output npc_pkg::back_stat_t             stat_o,
  output logic                            result_valid_o,
  output logic [npc_pkg::ChanW-1:0]       out_red_o,
  output logic [npc_pkg::ChanW-1:0]       out_green_o,
  output logic [npc_pkg::ChanW-1:0]       out_blue_o,
  output logic                            found_o,
  output logic [npc_pkg::IdxPortW-1:0]    found_index_o,
  output logic [npc_pkg::TotalW-1:0]      hit_total_o
);

  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned NumW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned RgbW = 3 * npc_pkg::ChanW;
  localparam int unsigned SqW  = 2 * npc_pkg::ChanW;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_HITWR = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_RDOUT = 3'd6;

  // Tables
  logic [RgbW-1:0]        rgb_mem [PALETTE_DEPTH];
  logic                   en_mem  [PALETTE_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_mem [PALETTE_DEPTH];

  logic [2:0]                state_q, state_d;
  logic [npc_pkg::SizeW-1:0] size_q;
  logic [IdxW-1:0]           sweep_q, sweep_d;
  logic [NumW-1:0]           scan_q, scan_d;
  logic [NumW-1:0]           num_used;
  npc_pkg::cmd_t             cmd_q, cmd_d;
  logic                      pop;

  // Table ports
  logic                   rgb_we, en_we, en_wd, cnt_we;
  logic [IdxW-1:0]        wr_addr, cnt_wa, cnt_ra, scan_addr;
  logic [COUNT_WIDTH-1:0] cnt_wd, cnt_rd_q, cnt_inc;
  logic [RgbW-1:0]        rgb_rd_q;
  logic                   en_rd_q;

  // Scan pipeline
  logic                    issue;
  logic                    rd_v_q;
  logic [IdxW-1:0]         rd_idx_q;
  logic                    sq_v_q;
  logic [IdxW-1:0]         sq_idx_q;
  logic [RgbW-1:0]         sq_rgb_q;
  logic [SqW-1:0]          sq_r_q, sq_g_q, sq_b_q;
  logic [npc_pkg::ChanW-1:0] dr, dg, db;
  logic [npc_pkg::DistW-1:0] dist_sum;
  logic                    have_q, have_clr;
  logic [npc_pkg::DistW-1:0] best_d_q;
  logic [IdxW-1:0]         best_i_q;
  logic [RgbW-1:0]         best_rgb_q;

  // Result assembly
  logic                        emit;
  logic [npc_pkg::ChanW-1:0]   e_red, e_green, e_blue;
  logic                        e_found;
  logic [npc_pkg::IdxPortW-1:0] e_idx;
  logic [npc_pkg::TotalW-1:0]  e_total;
  logic [COUNT_WIDTH-1:0]      rpt_in;
  logic [npc_pkg::TotalW-1:0]  rpt;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Clamp the entry count to the table depth
  always_comb begin
    if (32'(size_q) > PALETTE_DEPTH) begin
      num_used = NumW'(PALETTE_DEPTH);
    end else begin
      num_used = NumW'(size_q);
    end
  end

  assign scan_addr = IdxW'(scan_q);
  assign cnt_inc   = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;

  // Saturate the reported count to the result width
  assign rpt_in = (state_q == S_HITWR) ? cnt_inc : cnt_rd_q;
  assign rpt    = (|(rpt_in >> npc_pkg::TotalW)) ? '1 : npc_pkg::TotalW'(rpt_in);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    sweep_d  = sweep_q;
    scan_d   = scan_q;
    cmd_d    = cmd_q;
    pop      = 1'b0;
    issue    = 1'b0;
    have_clr = 1'b0;
    rgb_we   = 1'b0;
    en_we    = 1'b0;
    en_wd    = head_i.sel;
    wr_addr  = IdxW'(head_i.idx);
    cnt_we   = 1'b0;
    cnt_wa   = sweep_q;
    cnt_wd   = '0;
    cnt_ra   = IdxW'(head_i.idx);
    emit     = 1'b0;
    e_red    = '0;
    e_green  = '0;
    e_blue   = '0;
    e_found  = 1'b0;
    e_idx    = '0;
    e_total  = '0;
    case (state_q)
      S_INIT: begin
        // Sweep flags and counters to zero
        en_we   = 1'b1;
        en_wd   = 1'b0;
        wr_addr = sweep_q;
        cnt_we  = 1'b1;
        if (sweep_q == IdxW'(PALETTE_DEPTH - 1)) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop   = 1'b1;
          cmd_d = head_i;
          case (head_i.op)
            npc_pkg::OP_WRITE: begin
              rgb_we = head_i.idx_ok;
              en_we  = head_i.idx_ok;
              emit   = 1'b1;
            end
            npc_pkg::OP_CONVERT: begin
              if (num_used == '0) begin
                emit    = 1'b1;
                e_red   = head_i.red;
                e_green = head_i.green;
                e_blue  = head_i.blue;
              end else begin
                scan_d   = '0;
                have_clr = 1'b1;
                state_d  = S_SCAN;
              end
            end
            npc_pkg::OP_CLEAR: begin
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            npc_pkg::OP_READ: begin
              if (head_i.idx_ok) begin
                state_d = S_RDOUT;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue one entry a cycle, then let the pipeline drain
        if (scan_q < num_used) begin
          issue  = 1'b1;
          scan_d = scan_q + 1'b1;
        end else if (!rd_v_q && !sq_v_q) begin
          state_d = S_HIT;
        end
      end
      S_HIT: begin
        cnt_ra = best_i_q;
        if (have_q) begin
          state_d = S_HITWR;
        end else begin
          emit    = 1'b1;
          e_red   = cmd_q.red;
          e_green = cmd_q.green;
          e_blue  = cmd_q.blue;
          state_d = S_IDLE;
        end
      end
      S_HITWR: begin
        cnt_we  = 1'b1;
        cnt_wa  = best_i_q;
        cnt_wd  = cnt_inc;
        emit    = 1'b1;
        e_red   = best_rgb_q[RgbW-1 -: npc_pkg::ChanW];
        e_green = best_rgb_q[npc_pkg::ChanW +: npc_pkg::ChanW];
        e_blue  = best_rgb_q[npc_pkg::ChanW-1:0];
        e_found = 1'b1;
        e_idx   = npc_pkg::IdxPortW'(best_i_q);
        e_total = rpt;
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        cnt_we = 1'b1;
        if (sweep_q == IdxW'(PALETTE_DEPTH - 1)) begin
          sweep_d = '0;
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_RDOUT: begin
        emit    = 1'b1;
        e_total = rpt;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign stat_o.pop  = pop;
  assign stat_o.init = (state_q == S_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      sweep_q        <= '0;
      scan_q         <= '0;
      rd_v_q         <= 1'b0;
      sq_v_q         <= 1'b0;
      have_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      sweep_q        <= sweep_d;
      scan_q         <= scan_d;
      rd_v_q         <= issue;
      sq_v_q         <= rd_v_q && en_rd_q;
      result_valid_o <= emit;
      if (have_clr) begin
        have_q <= 1'b0;
      end else if (sq_v_q && (!have_q || dist_sum < best_d_q)) begin
        have_q <= 1'b1;
      end
    end
  end

  // Color and flag tables
  always_ff @(posedge clk_i) begin
    if (rgb_we) begin
      rgb_mem[wr_addr] <= {head_i.red, head_i.green, head_i.blue};
    end
    rgb_rd_q <= rgb_mem[scan_addr];
  end

  always_ff @(posedge clk_i) begin
    if (en_we) begin
      en_mem[wr_addr] <= en_wd;
    end
    en_rd_q <= en_mem[scan_addr];
  end

  // Hit counter table
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // Channel distances, squared into a register stage
  assign dr = (rgb_rd_q[RgbW-1 -: npc_pkg::ChanW] > cmd_q.red)
            ? rgb_rd_q[RgbW-1 -: npc_pkg::ChanW] - cmd_q.red
            : cmd_q.red - rgb_rd_q[RgbW-1 -: npc_pkg::ChanW];
  assign dg = (rgb_rd_q[npc_pkg::ChanW +: npc_pkg::ChanW] > cmd_q.green)
            ? rgb_rd_q[npc_pkg::ChanW +: npc_pkg::ChanW] - cmd_q.green
            : cmd_q.green - rgb_rd_q[npc_pkg::ChanW +: npc_pkg::ChanW];
  assign db = (rgb_rd_q[npc_pkg::ChanW-1:0] > cmd_q.blue)
            ? rgb_rd_q[npc_pkg::ChanW-1:0] - cmd_q.blue
            : cmd_q.blue - rgb_rd_q[npc_pkg::ChanW-1:0];

  assign dist_sum = npc_pkg::DistW'(sq_r_q) + npc_pkg::DistW'(sq_g_q)
                  + npc_pkg::DistW'(sq_b_q);

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rd_idx_q <= scan_addr;
    sq_idx_q <= rd_idx_q;
    sq_rgb_q <= rgb_rd_q;
    sq_r_q   <= {{npc_pkg::ChanW{1'b0}}, dr} * {{npc_pkg::ChanW{1'b0}}, dr};
    sq_g_q   <= {{npc_pkg::ChanW{1'b0}}, dg} * {{npc_pkg::ChanW{1'b0}}, dg};
    sq_b_q   <= {{npc_pkg::ChanW{1'b0}}, db} * {{npc_pkg::ChanW{1'b0}}, db};
    // Keep the first strict minimum
    if (sq_v_q && (!have_q || dist_sum < best_d_q)) begin
      best_d_q   <= dist_sum;
      best_i_q   <= sq_idx_q;
      best_rgb_q <= sq_rgb_q;
    end
  end

  // Result word registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_red_o     <= e_red;
      out_green_o   <= e_green;
      out_blue_o    <= e_blue;
      found_o       <= e_found;
      found_index_o <= e_idx;
      hit_total_o   <= e_total;
    end
  end

  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (state_q == S_IDLE) && head_valid_i)
    else $error("queue popped outside idle or while empty");

  a_no_pop_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !pop && !emit)
    else $error("command taken during table sweep");

  a_hit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HITWR) |-> cnt_we && (cnt_wd != '0))
    else $error("hit counter update wrote zero");

  a_pipe_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q |-> $past(rd_v_q))
    else $error("distance stage valid without a table read");

endmodule

>>> hw/rtl/nearest_palette_color_core.sv
// Top level of the nearest palette color core.
// A command word is taken when start is high and busy is low; a two-word queue
// lets words arrive while the previous one runs. Each command gives exactly one
// result word, shown for a single cycle with result_valid_o; the receiver has no
// way to stall it. After reset the core sweeps its flag and counter tables
// with busy high. A convert scans the palette size clamped to PALETTE_DEPTH,
// reading one palette entry per cycle from the color table through a
// square-and-compare pipeline, followed by a read-modify-write of the
// winner's hit counter when an enabled entry in range was found.
module nearest_palette_color_core #(
  parameter int unsigned PALETTE_DEPTH = 64,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [npc_pkg::SizeW-1:0]       cfg_wdata_i,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func_i,
  input  logic [npc_pkg::IdxPortW-1:0]    entry_index_i,
  input  logic [npc_pkg::ChanW-1:0]       color_red_i,
  input  logic [npc_pkg::ChanW-1:0]       color_green_i,
  input  logic [npc_pkg::ChanW-1:0]       color_blue_i,
  input  logic                            select_flag_i,
  output logic                            result_valid_o,
  output logic [npc_pkg::ChanW-1:0]       out_red_o,
  output logic [npc_pkg::ChanW-1:0]       out_green_o,
  output logic [npc_pkg::ChanW-1:0]       out_blue_o,
  output logic                            found_o,
  output logic [npc_pkg::IdxPortW-1:0]    found_index_o,
  output logic [npc_pkg::TotalW-1:0]      hit_total_o
);

  npc_pkg::cmd_t       head;
  logic                head_valid;
  npc_pkg::back_stat_t stat;

  npc_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .color_red_i   (color_red_i),
    .color_green_i (color_green_i),
    .color_blue_i  (color_blue_i),
    .select_flag_i (select_flag_i),
    .stat_i        (stat),
    .head_o        (head),
    .head_valid_o  (head_valid)
  );

  npc_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .found_o        (found_o),
    .found_index_o  (found_index_o),
    .hit_total_o    (hit_total_o)
  );

endmodule

>>> dv/nearest_palette_color_checker.sv
// Checker for the nearest palette color core: predicts every result word and compares it.
`timescale 1ns / 1ps
module nearest_palette_color_checker #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [npc_pkg::SizeW-1:0]    cfg_wdata_i,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   func_i,
  input  logic [npc_pkg::IdxPortW-1:0] entry_index_i,
  input  logic [npc_pkg::ChanW-1:0]    color_red_i,
  input  logic [npc_pkg::ChanW-1:0]    color_green_i,
  input  logic [npc_pkg::ChanW-1:0]    color_blue_i,
  input  logic                         select_flag_i,
  input  logic                         result_valid_o,
  input  logic [npc_pkg::ChanW-1:0]    out_red_o,
  input  logic [npc_pkg::ChanW-1:0]    out_green_o,
  input  logic [npc_pkg::ChanW-1:0]    out_blue_o,
  input  logic                         found_o,
  input  logic [npc_pkg::IdxPortW-1:0] found_index_o,
  input  logic [npc_pkg::TotalW-1:0]   hit_total_o,
  output int                           mismatch_count_o,
  output int                           pending_o,
  output int                           result_count_o,
  output int                           match_count_o
);

  // One predicted result word
  typedef struct packed {
    logic [npc_pkg::ChanW-1:0]    red;
    logic [npc_pkg::ChanW-1:0]    green;
    logic [npc_pkg::ChanW-1:0]    blue;
    logic                         found;
    logic [npc_pkg::IdxPortW-1:0] index;
    logic [npc_pkg::TotalW-1:0]   total;
  } quant_word_t;

  // Shadow copy of the palette, flags, hit counters and size register
  logic [3*npc_pkg::ChanW-1:0] color_table [PALETTE_DEPTH];
  bit                          enabled_tab [PALETTE_DEPTH];
  bit [npc_pkg::TotalW-1:0]    hit_tab     [PALETTE_DEPTH];
  logic [npc_pkg::SizeW-1:0]   size_reg;
  quant_word_t                 expected_words [$];

  function automatic int unsigned sq_gap(input logic [npc_pkg::ChanW-1:0] a,
                                         input logic [npc_pkg::ChanW-1:0] b);
    int unsigned d;
    d = (a > b) ? 32'(a - b) : 32'(b - a);
    return d * d;
  endfunction

  // Apply one command to the shadow state and return the word it should produce
  function automatic quant_word_t quantize(input npc_pkg::op_e op,
                                           input logic [npc_pkg::IdxPortW-1:0] idx,
                                           input logic [npc_pkg::ChanW-1:0] r,
                                           input logic [npc_pkg::ChanW-1:0] g,
                                           input logic [npc_pkg::ChanW-1:0] b,
                                           input logic sel);
    quant_word_t w;
    int unsigned span;
    int unsigned best_d;
    int unsigned d;
    int          best;
    int          i;
    bit          have;
    logic [3*npc_pkg::ChanW-1:0] c;
    w      = '0;
    have   = 1'b0;
    best   = 0;
    best_d = 0;
    case (op)
      npc_pkg::OP_WRITE: begin
        if (idx < PALETTE_DEPTH) begin
          color_table[idx] = {r, g, b};
          enabled_tab[idx] = sel;
        end
      end
      npc_pkg::OP_CONVERT: begin
        span = (size_reg > PALETTE_DEPTH) ? PALETTE_DEPTH : 32'(size_reg);
        // Strict less-than keeps the lowest index on a tie
        for (i = 0; i < span; i++) begin
          if (enabled_tab[i]) begin
            c = color_table[i];
            d = sq_gap(c[23:16], r) + sq_gap(c[15:8], g) + sq_gap(c[7:0], b);
            if (!have || d < best_d) begin
              have   = 1'b1;
              best_d = d;
              best   = i;
            end
          end
        end
        if (have) begin
          c = color_table[best];
          if (hit_tab[best] != '1) hit_tab[best] = hit_tab[best] + 1'b1;
          w.red   = c[23:16];
          w.green = c[15:8];
          w.blue  = c[7:0];
          w.found = 1'b1;
          w.index = best[npc_pkg::IdxPortW-1:0];
          w.total = hit_tab[best];
        end else begin
          // Pass the pixel through untouched
          w.red   = r;
          w.green = g;
          w.blue  = b;
        end
      end
      npc_pkg::OP_CLEAR: begin
        for (i = 0; i < PALETTE_DEPTH; i++) hit_tab[i] = '0;
      end
      default: begin
        if (idx < PALETTE_DEPTH) w.total = hit_tab[idx];
      end
    endcase
    return w;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Compare the result word first, then log the command accepted at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    quant_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        color_table[i] = '0;
        enabled_tab[i] = 1'b0;
        hit_tab[i]     = '0;
      end
      size_reg = '0;
      expected_words.delete();
      mismatch_count_o = 0;
      result_count_o   = 0;
      match_count_o    = 0;
    end else begin
      if (result_valid_o) begin
        result_count_o++;
        if (found_o) match_count_o++;
        if (expected_words.size() == 0) begin
          $error("result word with no command waiting for it");
          mismatch_count_o++;
        end else begin
          want = expected_words.pop_front();
          check_field("out_red", want.red, out_red_o);
          check_field("out_green", want.green, out_green_o);
          check_field("out_blue", want.blue, out_blue_o);
          check_field("found", want.found, found_o);
          check_field("found_index", want.index, found_index_o);
          check_field("hit_total", want.total, hit_total_o);
        end
      end
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (start && !busy) begin
        expected_words.insert(expected_words.size(),
                              quantize(npc_pkg::op_e'(func_i), entry_index_i, color_red_i,
                                       color_green_i, color_blue_i, select_flag_i));
      end
    end
    pending_o = expected_words.size();
  end

endmodule

>>> dv/nearest_palette_color_core_tb.sv
// Testbench top for the nearest palette color core: drives command words and gives the verdict.
`timescale 1ns / 1ps
module nearest_palette_color_core_tb;

  localparam int unsigned Depth      = 64;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumPhases  = 11;
  localparam int unsigned PhaseItems = 50;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [npc_pkg::SizeW-1:0]    cfg_wdata_i;
  logic                         start;
  logic                         busy;
  logic [1:0]                   func_i;
  logic [npc_pkg::IdxPortW-1:0] entry_index_i;
  logic [npc_pkg::ChanW-1:0]    color_red_i;
  logic [npc_pkg::ChanW-1:0]    color_green_i;
  logic [npc_pkg::ChanW-1:0]    color_blue_i;
  logic                         select_flag_i;
  logic                         result_valid_o;
  logic [npc_pkg::ChanW-1:0]    out_red_o;
  logic [npc_pkg::ChanW-1:0]    out_green_o;
  logic [npc_pkg::ChanW-1:0]    out_blue_o;
  logic                         found_o;
  logic [npc_pkg::IdxPortW-1:0] found_index_o;
  logic [npc_pkg::TotalW-1:0]   hit_total_o;

  int mismatch_count;
  int pending_words;
  int result_count;
  int match_count;

  // Stimulus bookkeeping: colors already loaded, used to aim pixels near them
  logic [3*npc_pkg::ChanW-1:0] loaded_rgb [Depth];
  bit                          loaded     [Depth];
  logic [npc_pkg::SizeW-1:0]   size_now;
  logic [npc_pkg::SizeW-1:0]   phase_sizes [NumPhases] =
    '{7'd1, 7'd64, 7'd127, 7'd0, 7'd17, 7'd2, 7'd64, 7'd100, 7'd5, 7'd33, 7'd64};
  int n_write, n_convert, n_clear, n_read, n_sizes;
  int unsigned stall_cycles;

  nearest_palette_color_core #(
    .PALETTE_DEPTH(Depth),
    .COUNT_WIDTH  (32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .color_red_i   (color_red_i),
    .color_green_i (color_green_i),
    .color_blue_i  (color_blue_i),
    .select_flag_i (select_flag_i),
    .result_valid_o(result_valid_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .found_o       (found_o),
    .found_index_o (found_index_o),
    .hit_total_o   (hit_total_o)
  );

  nearest_palette_color_checker #(
    .PALETTE_DEPTH(Depth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .color_red_i     (color_red_i),
    .color_green_i   (color_green_i),
    .color_blue_i    (color_blue_i),
    .select_flag_i   (select_flag_i),
    .result_valid_o  (result_valid_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .found_o         (found_o),
    .found_index_o   (found_index_o),
    .hit_total_o     (hit_total_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_words),
    .result_count_o  (result_count),
    .match_count_o   (match_count)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Abort when neither a command nor a result moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one command word and hold it until the core takes it
  task automatic issue_word(input npc_pkg::op_e op,
                            input logic [npc_pkg::IdxPortW-1:0] idx,
                            input logic [npc_pkg::ChanW-1:0] r,
                            input logic [npc_pkg::ChanW-1:0] g,
                            input logic [npc_pkg::ChanW-1:0] b, input logic sel);
    @(negedge clk_i);
    start         <= 1'b1;
    func_i        <= op;
    entry_index_i <= idx;
    color_red_i   <= r;
    color_green_i <= g;
    color_blue_i  <= b;
    select_flag_i <= sel;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (op)
      npc_pkg::OP_WRITE: begin
        n_write++;
        loaded_rgb[idx] = {r, g, b};
        loaded[idx]     = 1'b1;
      end
      npc_pkg::OP_CONVERT: n_convert++;
      npc_pkg::OP_CLEAR:   n_clear++;
      default:             n_read++;
    endcase
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drain the core, then write the palette size register
  task automatic set_size(input logic [npc_pkg::SizeW-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_words != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_now = value;
    n_sizes++;
  endtask

  function automatic logic [npc_pkg::ChanW-1:0] nudge(input logic [npc_pkg::ChanW-1:0] c);
    int v;
    v = int'(c);
    v = v + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[npc_pkg::ChanW-1:0];
  endfunction

  // Mostly writes into the active span and converts aimed near loaded colors
  task automatic random_word();
    int unsigned pick;
    int unsigned k;
    int unsigned span;
    logic [npc_pkg::IdxPortW-1:0] idx;
    logic [npc_pkg::ChanW-1:0]    r, g, b;
    logic [3*npc_pkg::ChanW-1:0]  base;
    span = (size_now == 0) ? 1 : ((size_now > Depth) ? Depth : 32'(size_now));
    pick = $urandom_range(0, 99);
    idx  = npc_pkg::IdxPortW'($urandom);
    r    = npc_pkg::ChanW'($urandom);
    g    = npc_pkg::ChanW'($urandom);
    b    = npc_pkg::ChanW'($urandom);
    if (pick < 30) begin
      if ($urandom_range(0, 3) != 0) idx = npc_pkg::IdxPortW'($urandom_range(0, span - 1));
      // Copy an existing color now and then to force ties
      k = $urandom_range(0, Depth - 1);
      if ($urandom_range(0, 4) == 0 && loaded[k]) {r, g, b} = loaded_rgb[k];
      issue_word(npc_pkg::OP_WRITE, idx, r, g, b, $urandom_range(0, 4) != 0);
    end else if (pick < 80) begin
      k = $urandom_range(0, span - 1);
      if ($urandom_range(0, 1) == 1 && loaded[k]) begin
        base = loaded_rgb[k];
        r    = nudge(base[23:16]);
        g    = nudge(base[15:8]);
        b    = nudge(base[7:0]);
      end else if ($urandom_range(0, 9) == 0) begin
        {r, g, b} = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      issue_word(npc_pkg::OP_CONVERT, idx, r, g, b, $urandom_range(0, 1) == 1);
    end else if (pick < 95) begin
      issue_word(npc_pkg::OP_READ, idx, r, g, b, $urandom_range(0, 1) == 1);
    end else begin
      issue_word(npc_pkg::OP_CLEAR, idx, r, g, b, $urandom_range(0, 1) == 1);
    end
  endtask

  initial begin
    bit calm;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    func_i        = npc_pkg::OP_WRITE;
    entry_index_i = '0;
    color_red_i   = '0;
    color_green_i = '0;
    color_blue_i  = '0;
    select_flag_i = 1'b0;
    stall_cycles  = 0;
    size_now      = '0;
    for (int i = 0; i < Depth; i++) loaded[i] = 1'b0;
    phase_sizes[8] = npc_pkg::SizeW'($urandom_range(3, Depth));
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty palette, extremes, ties, disabled entry, clamped size
    set_size(7'd0);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_CONVERT, 6'd63, 8'hff, 8'hff, 8'hff, 1'b1);
    issue_word(npc_pkg::OP_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_READ, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_READ, 6'd63, 8'hff, 8'hff, 8'hff, 1'b1);
    set_size(7'd64);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'h12, 8'h34, 8'h56, 1'b0);
    issue_word(npc_pkg::OP_WRITE, 6'd0, 8'hff, 8'h00, 8'hff, 1'b1);
    issue_word(npc_pkg::OP_WRITE, 6'd63, 8'h00, 8'hff, 8'h00, 1'b1);
    issue_word(npc_pkg::OP_WRITE, 6'd1, 8'hff, 8'h00, 8'hff, 1'b1);
    issue_word(npc_pkg::OP_WRITE, 6'd2, 8'h80, 8'h80, 8'h80, 1'b0);
    set_size(7'd0);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'hff, 8'h00, 8'hff, 1'b0);
    set_size(7'd2);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'hff, 8'h00, 8'hff, 1'b0);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'h00, 8'hff, 8'h00, 1'b0);
    set_size(7'd127);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'h00, 8'hff, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'h80, 8'h80, 8'h80, 1'b0);
    issue_word(npc_pkg::OP_READ, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_CLEAR, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_READ, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    issue_word(npc_pkg::OP_WRITE, 6'd2, 8'h80, 8'h80, 8'h80, 1'b1);
    issue_word(npc_pkg::OP_CONVERT, 6'd0, 8'h7f, 8'h7f, 8'h7f, 1'b0);
    issue_word(npc_pkg::OP_READ, 6'd2, 8'h00, 8'h00, 8'h00, 1'b0);

    // Random phases, one palette size each; the last phase runs back to back
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_size(phase_sizes[ph]);
      calm = (ph == NumPhases - 1) || ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        random_word();
        if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
      end
    end

    // Drain, then allow the tail of the last counter update to settle
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d writes, %0d converts (%0d hit an entry), %0d reads, %0d clears",
             n_write, n_convert, match_count, n_read, n_clear);
    $display("over %0d palette size settings; %0d result words checked", n_sizes,
             result_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
